// ===== rtl/sdsr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive status responder package
// Request codes, configuration indexes, frame and reply constants, the
// checksum function and the control structs shared by the responder modules.
// ----------------------------------------------------------------------------
package sdsr_pkg;

    // Request kinds carried in tuser
    localparam logic [1:0] REQ_LINE = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACK_DELAY  = 2'd0;
    localparam logic [1:0] CFG_BIT_PERIOD = 2'd1;
    localparam logic [1:0] CFG_GAP_DELAY  = 2'd2;

    localparam logic [15:0] ACK_DELAY_RST  = 16'd256;
    localparam logic [15:0] BIT_PERIOD_RST = 16'd64;
    localparam logic [15:0] GAP_DELAY_RST  = 16'd64;

    // Command frame layout: device, command, two auxiliary bytes, checksum
    localparam int unsigned FRAME_LEN = 5;
    localparam logic [7:0]  DEV_ID     = 8'h31;
    localparam logic [7:0]  CMD_STATUS = 8'h53;

    // Reply bytes
    localparam logic [7:0]  BYTE_NAK  = 8'h4E;
    localparam logic [7:0]  BYTE_ACK  = 8'h41;
    localparam logic [7:0]  BYTE_DONE = 8'h43;
    // Status bytes, first byte in the lowest bits
    localparam logic [31:0] STATUS_WORD = 32'h00FE_FF10;
    localparam logic [2:0]  REPLY_LEN_NAK  = 3'd1;
    localparam logic [2:0]  REPLY_LEN_GOOD = 3'd7;

    // Serializer bit positions: start bit is 0, data 1..8, stop 9
    localparam logic [3:0] BIT_IDLE = 4'd15;
    localparam logic [3:0] BIT_DATA_LAST = 4'd8;
    localparam logic [3:0] BIT_STOP = 4'd9;

    typedef struct packed {
        logic [15:0] ack_delay;
        logic [15:0] bit_period;
        logic [15:0] gap_delay;
    } sdsr_cfg_t;

    // One step request to the serializer
    typedef struct packed {
        logic tick;
        logic load;
        logic good;
        logic cancel;
    } sdsr_ser_ctrl_t;

    // Line state after the step
    typedef struct packed {
        logic reply_pending;
        logic line_level;
    } sdsr_ser_stat_t;

    // 8-bit end-around-carry sum of four bytes, first byte lowest
    function automatic logic [7:0] eac_sum4(input logic [31:0] w);
        logic [8:0] s;
        s = 9'd0;
        for (int i = 0; i < 4; i++) begin
            s = {1'b0, s[7:0]} + {1'b0, w[8*i +: 8]};
            s = {1'b0, s[7:0]} + {8'd0, s[8]};
        end
        return s[7:0];
    endfunction

    localparam logic [7:0] STATUS_SUM = eac_sum4(STATUS_WORD);

    // Reply byte at a queue position
    function automatic logic [7:0] reply_byte(input logic good, input logic [2:0] idx);
        logic [7:0] b;
        if (!good) begin
            b = BYTE_NAK;
        end else begin
            case (idx)
                3'd0:    b = BYTE_ACK;
                3'd1:    b = BYTE_DONE;
                3'd2:    b = STATUS_WORD[7:0];
                3'd3:    b = STATUS_WORD[15:8];
                3'd4:    b = STATUS_WORD[23:16];
                3'd5:    b = STATUS_WORD[31:24];
                3'd6:    b = STATUS_SUM;
                default: b = 8'h00;
            endcase
        end
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/sdsr_serializer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive status reply serializer
// Holds the reply queue position and sends each byte as start bit, eight
// data bits LSB first and stop bit, with acknowledge and gap delays.
// ----------------------------------------------------------------------------
module sdsr_serializer
    import sdsr_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire sdsr_ser_ctrl_t ctrl,
    input  wire sdsr_cfg_t      cfg,
    output sdsr_ser_stat_t      stat
);

    logic        good_reg,     good_next;
    logic [2:0]  count_reg,    count_next;
    logic [2:0]  index_reg,    index_next;
    logic [3:0]  bit_pos_reg,  bit_pos_next;
    logic [15:0] bit_timer_reg, bit_timer_next;
    logic [15:0] gap_timer_reg, gap_timer_next;
    logic        line_reg,     line_next;

    logic [15:0] period;
    logic [15:0] timer_dec;
    logic [3:0]  pos_inc;
    logic [7:0]  cur_byte;

    // Zero period counts as one tick
    assign period    = (cfg.bit_period == 16'd0) ? 16'd1 : cfg.bit_period;
    assign timer_dec = (bit_timer_reg != 16'd0) ? bit_timer_reg - 16'd1 : 16'd0;
    assign pos_inc   = bit_pos_reg + 4'd1;
    assign cur_byte  = reply_byte(good_reg, index_reg);

    // Advance the queue and bit timing for one request
    always_comb begin
        good_next      = good_reg;
        count_next     = count_reg;
        index_next     = index_reg;
        bit_pos_next   = bit_pos_reg;
        bit_timer_next = bit_timer_reg;
        gap_timer_next = gap_timer_reg;
        line_next      = line_reg;
        if (ctrl.cancel) begin
            count_next   = 3'd0;
            index_next   = 3'd0;
            bit_pos_next = BIT_IDLE;
            line_next    = 1'b1;
        end else if (ctrl.load) begin
            good_next      = ctrl.good;
            count_next     = ctrl.good ? REPLY_LEN_GOOD : REPLY_LEN_NAK;
            index_next     = 3'd0;
            gap_timer_next = cfg.ack_delay;
        end else if (ctrl.tick) begin
            if (bit_pos_reg == BIT_IDLE) begin
                if (index_reg < count_reg) begin
                    if (gap_timer_reg != 16'd0) begin
                        gap_timer_next = gap_timer_reg - 16'd1;
                    end else begin
                        bit_pos_next   = 4'd0;
                        bit_timer_next = period;
                        line_next      = 1'b0;
                    end
                end
            end else if (timer_dec != 16'd0) begin
                bit_timer_next = timer_dec;
            end else begin
                bit_pos_next = pos_inc;
                if (pos_inc <= BIT_DATA_LAST) begin
                    line_next      = cur_byte[bit_pos_reg[2:0]];
                    bit_timer_next = period;
                end else if (pos_inc == BIT_STOP) begin
                    line_next      = 1'b1;
                    bit_timer_next = period;
                end else begin
                    bit_timer_next = timer_dec;
                    index_next     = index_reg + 3'd1;
                    bit_pos_next   = BIT_IDLE;
                    line_next      = 1'b1;
                    gap_timer_next = cfg.gap_delay;
                end
            end
        end
    end

    // Report the line as it stands after this step
    always_comb begin
        stat.line_level    = line_next;
        stat.reply_pending = (index_next < count_next) || (bit_pos_next != BIT_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            good_reg      <= 1'b0;
            count_reg     <= 3'd0;
            index_reg     <= 3'd0;
            bit_pos_reg   <= BIT_IDLE;
            bit_timer_reg <= 16'd0;
            gap_timer_reg <= 16'd0;
            line_reg      <= 1'b1;
        end else begin
            good_reg      <= good_next;
            count_reg     <= count_next;
            index_reg     <= index_next;
            bit_pos_reg   <= bit_pos_next;
            bit_timer_reg <= bit_timer_next;
            gap_timer_reg <= gap_timer_next;
            line_reg      <= line_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/serial_drive_status_responder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial drive status responder
// Collects command frames while the command line is held, checks them on
// release and serializes the status reply or a NAK onto the data line.
//
// Usage:
//   s_ channel: one request per transfer. s_tuser selects line change, received
//   byte or time tick; s_tdata carries the new command level and the byte.
//   m_ channel: one result per request, the data line level and a reply
//   pending flag after that request has taken effect.
//   cfg port: write ack delay, bit period and gap delay while idle; index 3
//   is ignored.
//   Every request is handled combinationally by the frame checker and the
//   serializer step and its result is registered; a request can be taken on
//   every cycle while the skid entry is empty.
//   A two-entry output stage (result register plus skid register) takes one
//   request into the skid register while m_tready stalls the result; s_tready
//   then drops until the skid entry drains.
//   Reset clears the command level, frame count and reply queue, puts the
//   line at mark and loads the default delays.
// ----------------------------------------------------------------------------
module serial_drive_status_responder
    import sdsr_pkg::*;
#(
    parameter int FRAME_DEPTH = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [0] cmd_asserted, [8:1] rx_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [0] line_level, [1] reply_pending
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int CNT_W = $clog2(FRAME_DEPTH + 1);

    logic                 accept;
    logic                 cmd_in;
    logic [7:0]           byte_in;

    logic                 cmd_level_reg, cmd_level_next;
    logic [CNT_W-1:0]     frame_count_reg, frame_count_next;
    logic [7:0]           frame_reg [FRAME_LEN];
    logic                 frame_wr;
    logic                 frame_good;

    sdsr_cfg_t            cfg_reg;
    sdsr_ser_ctrl_t       ser_ctrl;
    sdsr_ser_stat_t       ser_stat;

    sdsr_ser_stat_t       out_data_reg, skid_data_reg;
    logic                 out_valid_reg, skid_valid_reg;

    assign accept  = s_tvalid && s_tready;
    assign cmd_in  = s_tdata[0];
    assign byte_in = s_tdata[8:1];

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ack_delay  <= ACK_DELAY_RST;
            cfg_reg.bit_period <= BIT_PERIOD_RST;
            cfg_reg.gap_delay  <= GAP_DELAY_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ACK_DELAY:  cfg_reg.ack_delay  <= cfg_data;
                CFG_BIT_PERIOD: cfg_reg.bit_period <= cfg_data;
                CFG_GAP_DELAY:  cfg_reg.gap_delay  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Check the held frame: length, device, command and checksum
    assign frame_good = (frame_count_reg == CNT_W'(FRAME_LEN))
                     && (frame_reg[0] == DEV_ID)
                     && (frame_reg[1] == CMD_STATUS)
                     && (eac_sum4({frame_reg[3], frame_reg[2], frame_reg[1], frame_reg[0]})
                         == frame_reg[4]);

    // Decode the request into frame updates and a serializer step
    always_comb begin
        cmd_level_next   = cmd_level_reg;
        frame_count_next = frame_count_reg;
        frame_wr         = 1'b0;
        ser_ctrl         = '0;
        if (accept) begin
            case (s_tuser)
                REQ_LINE: begin
                    if (cmd_in != cmd_level_reg) begin
                        cmd_level_next = cmd_in;
                        if (cmd_in) begin
                            frame_count_next = '0;
                            ser_ctrl.cancel  = 1'b1;
                        end else begin
                            ser_ctrl.load = 1'b1;
                            ser_ctrl.good = frame_good;
                        end
                    end
                end
                REQ_BYTE: begin
                    if (cmd_level_reg && (frame_count_reg < CNT_W'(FRAME_DEPTH))) begin
                        frame_wr         = frame_count_reg < CNT_W'(FRAME_LEN);
                        frame_count_next = frame_count_reg + CNT_W'(1);
                    end
                end
                REQ_TICK: begin
                    ser_ctrl.tick = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_level_reg   <= 1'b0;
            frame_count_reg <= '0;
        end else begin
            cmd_level_reg   <= cmd_level_next;
            frame_count_reg <= frame_count_next;
        end
    end

    // Store the checked bytes of the frame; later bytes only count
    always_ff @(posedge aclk) begin
        if (frame_wr) begin
            frame_reg[frame_count_reg[2:0]] <= byte_in;
        end
    end

    sdsr_serializer u_serializer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ser_ctrl),
        .cfg     (cfg_reg),
        .stat    (ser_stat)
    );

    // Result register with skid entry
    assign s_tready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : ser_stat;
        end else if (accept) begin
            skid_data_reg <= ser_stat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg.reply_pending, out_data_reg.line_level};

endmodule
`default_nettype wire

// ===== rtl/sdsr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Drive status responder port checker
// Watches the request and result channels of the responder over time.
// ----------------------------------------------------------------------------
module sdsr_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    // Hold a stalled result
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Present a result the cycle after a request is taken
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accepted request");

    // Keep the line at mark whenever no reply is pending
    a_idle_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[0])
        else $error("line at space with no reply pending");

    // Leave reset with no result shown
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind serial_drive_status_responder sdsr_checker u_sdsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
